FILE: hdl/tpstk_pkg.sv
// ----------------------------------------------------------------------------
// tpstk_pkg: shared definitions of the two-class priority stack
// Operation and status codes, and the control word that the core broadcasts
// to every cell of the stack.
// ----------------------------------------------------------------------------
package tpstk_pkg;

    localparam logic [1:0] OP_PUSH          = 2'd0;
    localparam logic [1:0] OP_PRIORITY_PUSH = 2'd1;
    localparam logic [1:0] OP_POP           = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_INSERT,
        CELL_POP
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       new_pri;
    } cell_ctrl_t;

endpackage

FILE: hdl/tpstk_cell.sv
// ----------------------------------------------------------------------------
// tpstk_cell: one slot of the stack
// Holds one entry, its class bit and an occupancy bit, and exchanges them
// with the slots above and below. Slot 0 is the top of the stack.
// ----------------------------------------------------------------------------
module tpstk_cell
    import tpstk_pkg::*;
#(
    parameter int ENTRY_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cell_ctrl_t             ctrl,
    input  logic [ENTRY_WIDTH-1:0] new_entry,
    input  logic [ENTRY_WIDTH-1:0] above_entry,
    input  logic                   above_pri,
    input  logic                   above_occ,
    input  logic [ENTRY_WIDTH-1:0] below_entry,
    input  logic                   below_pri,
    input  logic                   below_occ,
    input  logic                   run_in,
    output logic                   run_out,
    output logic [ENTRY_WIDTH-1:0] entry_q,
    output logic                   pri_q,
    output logic                   occ_q,
    output logic [ENTRY_WIDTH-1:0] entry_d,
    output logic                   pri_d
);

    logic [ENTRY_WIDTH-1:0] entry_reg;
    logic [ENTRY_WIDTH-1:0] entry_next;
    logic                   pri_reg;
    logic                   pri_next;
    logic                   occ_reg;
    logic                   occ_next;
    logic                   in_run;

    assign in_run  = occ_reg & pri_reg;
    assign run_out = run_in & in_run;

    always_comb begin
        entry_next = entry_reg;
        pri_next   = pri_reg;
        occ_next   = occ_reg;
        case (ctrl.mode)
            CELL_HOLD: begin
            end
            CELL_PUSH: begin
                entry_next = above_entry;
                pri_next   = above_pri;
                occ_next   = above_occ;
            end
            CELL_INSERT: begin
                if (run_in && in_run) begin
                    entry_next = entry_reg;
                end else if (run_in) begin
                    entry_next = new_entry;
                    pri_next   = ctrl.new_pri;
                    occ_next   = 1'b1;
                end else begin
                    entry_next = above_entry;
                    pri_next   = above_pri;
                    occ_next   = above_occ;
                end
            end
            CELL_POP: begin
                entry_next = below_entry;
                pri_next   = below_pri;
                occ_next   = below_occ;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        pri_reg   <= pri_next;
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign entry_q = entry_reg;
    assign pri_q   = pri_reg;
    assign occ_q   = occ_reg;
    assign entry_d = entry_next;
    assign pri_d   = pri_next;

endmodule

FILE: hdl/two_class_priority_stack_core.sv
// ----------------------------------------------------------------------------
// two_class_priority_stack_core: bounded LIFO with two priority classes
// Usage:
//   Items arrive on the s_ channel. tdata holds the operation (plain push,
//   priority push, pop) and the identifier; tuser holds the class bit. A
//   priority push of an ordinary entry lands directly below the run of
//   priority entries at the top; every other push lands on top.
//   Each item yields one result item on the m_ channel with the top entry,
//   its class (in tuser), the empty flag, the entry count and a status.
//   The stack is a row of DEPTH identical cells; the insert position is
//   found by a ripple through the cells and all cells shift in the same
//   cycle, so one item is taken per cycle while the receiver keeps up,
//   and its result is presented in the cycle after acceptance.
//   An item is taken while the output register is empty or being emptied,
//   so a stalled receiver holds the input side after one waiting result.
//   After reset the stack is empty and no result is pending.
// ----------------------------------------------------------------------------
module two_class_priority_stack_core
    import tpstk_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // func [1:0], entry_id [17:2], zero [23:18]
    input  logic        s_tuser,   // is_priority [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // top_entry [15:0], is_empty [16],
                                   // entry_count [21:17], status [23:22]
    output logic        m_tuser    // top_is_priority [0]
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [1:0]              in_func;
    logic [15:0]             in_id;
    logic [ENTRY_WIDTH+15:0] id_ext;
    logic [ENTRY_WIDTH-1:0]  new_entry;
    logic                    accept;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    cell_mode_t    mode;
    logic [1:0]    status;
    cell_ctrl_t    ctrl;

    logic [ENTRY_WIDTH-1:0] cell_entry   [DEPTH];
    logic                   cell_pri     [DEPTH];
    logic                   cell_occ     [DEPTH];
    logic [ENTRY_WIDTH-1:0] cell_entry_d [DEPTH];
    logic                   cell_pri_d   [DEPTH];
    logic                   run          [DEPTH+1];
    logic [ENTRY_WIDTH-1:0] top_entry_d;
    logic                   top_pri_d;

    logic [ENTRY_WIDTH+15:0] top_ext;
    logic [CW+4:0]           cnt_ext;

    logic        m_valid_reg;
    logic [15:0] m_entry_reg;
    logic        m_pri_reg;
    logic        m_empty_reg;
    logic [4:0]  m_count_reg;
    logic [1:0]  m_status_reg;

    assign in_func   = s_tdata[1:0];
    assign in_id     = s_tdata[17:2];
    assign id_ext    = {{ENTRY_WIDTH{1'b0}}, in_id};
    assign new_entry = id_ext[ENTRY_WIDTH-1:0];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        mode     = CELL_HOLD;
        status   = ST_OK;
        cnt_next = cnt_reg;
        case (in_func)
            OP_PUSH, OP_PRIORITY_PUSH: begin
                if (cnt_reg == FULL_CNT) begin
                    status = ST_PUSH_FULL;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                    if (in_func == OP_PRIORITY_PUSH && !s_tuser) begin
                        mode = CELL_INSERT;
                    end else begin
                        mode = CELL_PUSH;
                    end
                end
            end
            OP_POP: begin
                if (cnt_reg == '0) begin
                    status = ST_POP_EMPTY;
                end else begin
                    cnt_next = cnt_reg - CW'(1);
                    mode     = CELL_POP;
                end
            end
            default: begin
            end
        endcase
        ctrl.mode    = accept ? mode : CELL_HOLD;
        ctrl.new_pri = s_tuser;
    end

    assign run[0] = 1'b1;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] above_entry;
        logic                   above_pri;
        logic                   above_occ;
        logic [ENTRY_WIDTH-1:0] below_entry;
        logic                   below_pri;
        logic                   below_occ;

        if (i == 0) begin : g_top
            assign above_entry = new_entry;
            assign above_pri   = s_tuser;
            assign above_occ   = 1'b1;
            assign top_entry_d = cell_entry_d[i];
            assign top_pri_d   = cell_pri_d[i];
        end else begin : g_mid
            assign above_entry = cell_entry[i-1];
            assign above_pri   = cell_pri[i-1];
            assign above_occ   = cell_occ[i-1];
        end

        if (i == DEPTH - 1) begin : g_bottom
            assign below_entry = '0;
            assign below_pri   = 1'b0;
            assign below_occ   = 1'b0;
        end else begin : g_upper
            assign below_entry = cell_entry[i+1];
            assign below_pri   = cell_pri[i+1];
            assign below_occ   = cell_occ[i+1];
        end

        tpstk_cell #(
            .ENTRY_WIDTH (ENTRY_WIDTH)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .above_entry (above_entry),
            .above_pri   (above_pri),
            .above_occ   (above_occ),
            .below_entry (below_entry),
            .below_pri   (below_pri),
            .below_occ   (below_occ),
            .run_in      (run[i]),
            .run_out     (run[i+1]),
            .entry_q     (cell_entry[i]),
            .pri_q       (cell_pri[i]),
            .occ_q       (cell_occ[i]),
            .entry_d     (cell_entry_d[i]),
            .pri_d       (cell_pri_d[i])
        );
    end

    assign top_ext = {16'b0, top_entry_d};
    assign cnt_ext = {5'b0, cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg     <= cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_status_reg <= status;
            m_count_reg  <= cnt_ext[4:0];
            if (cnt_next == '0) begin
                m_entry_reg <= '0;
                m_pri_reg   <= 1'b0;
                m_empty_reg <= 1'b1;
            end else begin
                m_entry_reg <= top_ext[15:0];
                m_pri_reg   <= top_pri_d;
                m_empty_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_status_reg, m_count_reg, m_empty_reg, m_entry_reg};
    assign m_tuser  = m_pri_reg;

endmodule

FILE: test/tpstk_stack_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpstk_stack_checker: result checker for the two-class priority stack
// Watches both channels of the core, keeps its own copy of the stack, works
// out the result of every accepted item and compares each result item with
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module tpstk_stack_checker
    import tpstk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending,
    output int          n_results,
    output int          n_full,
    output int          n_empty_pop,
    output int          n_buried,
    output int          n_peak
);

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [15:0] top_entry;
        logic        top_pri;
        logic        empty;
        logic [4:0]  count;
        logic [1:0]  status;
    } stack_view_t;

    logic [15:0]  stack_id [DEPTH];
    logic         stack_pri [DEPTH];
    int           stack_fill;
    stack_view_t  awaited_views [$];

    initial begin
        fail_count  = 0;
        pending     = 0;
        n_results   = 0;
        n_full      = 0;
        n_empty_pop = 0;
        n_buried    = 0;
        n_peak      = 0;
        stack_fill  = 0;
    end

    function automatic stack_view_t next_stack_view(input logic [1:0] op,
                                                    input logic [15:0] id,
                                                    input logic pri);
        stack_view_t v;
        int          pos;
        v.status = ST_OK;
        case (op)
            OP_PUSH, OP_PRIORITY_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    v.status = ST_PUSH_FULL;
                    n_full++;
                end else begin
                    pos = stack_fill;
                    if (op == OP_PRIORITY_PUSH && !pri) begin
                        while (pos > 0 && stack_pri[pos - 1])
                            pos--;
                    end
                    if (pos != stack_fill)
                        n_buried++;
                    for (int i = stack_fill; i > pos; i--) begin
                        stack_id[i]  = stack_id[i - 1];
                        stack_pri[i] = stack_pri[i - 1];
                    end
                    stack_id[pos]  = id;
                    stack_pri[pos] = pri;
                    stack_fill++;
                    if (stack_fill > n_peak)
                        n_peak = stack_fill;
                end
            end
            OP_POP: begin
                if (stack_fill == 0) begin
                    v.status = ST_POP_EMPTY;
                    n_empty_pop++;
                end else begin
                    stack_fill--;
                end
            end
            default: ;
        endcase
        if (stack_fill == 0) begin
            v.top_entry = '0;
            v.top_pri   = 1'b0;
            v.empty     = 1'b1;
        end else begin
            v.top_entry = stack_id[stack_fill - 1];
            v.top_pri   = stack_pri[stack_fill - 1];
            v.empty     = 1'b0;
        end
        v.count = 5'(stack_fill);
        return v;
    endfunction

    always @(posedge aclk) begin : watch
        stack_view_t want;
        stack_view_t got;
        if (!aresetn) begin
            stack_fill = 0;
            awaited_views.delete();
            pending = 0;
        end else begin
            if (s_tvalid && s_tready)
                awaited_views.push_back(next_stack_view(s_tdata[1:0], s_tdata[17:2],
                                                        s_tuser));
            if (m_tvalid && m_tready) begin
                got.top_entry = m_tdata[15:0];
                got.empty     = m_tdata[16];
                got.count     = m_tdata[21:17];
                got.status    = m_tdata[23:22];
                got.top_pri   = m_tuser;
                n_results++;
                if (awaited_views.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Result %0d arrived with no item outstanding: top=%h pri=%b",
                                 n_results, got.top_entry, got.top_pri);
                end else begin
                    want = awaited_views.pop_front();
                    if (got.top_entry !== want.top_entry || got.top_pri !== want.top_pri ||
                        got.empty !== want.empty || got.count !== want.count ||
                        got.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("Result %0d expected: top=%h pri=%b empty=%b cnt=%0d st=%0d",
                                     n_results, want.top_entry, want.top_pri, want.empty,
                                     want.count, want.status);
                            $display("Result %0d actual:   top=%h pri=%b empty=%b cnt=%0d st=%0d",
                                     n_results, got.top_entry, got.top_pri, got.empty,
                                     got.count, got.status);
                        end
                    end
                end
            end
            pending = awaited_views.size();
        end
    end

endmodule

FILE: test/two_class_priority_stack_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_class_priority_stack_core_tb: testbench of the two-class priority stack
// Drives a directed opening sequence, then bursts of random pushes, pops and
// unused codes through four phases of sender and receiver idling, with long
// receiver hold-offs in the first and last phases and a full drain after each
// phase. The checker beside the core predicts and compares every result item.
// ----------------------------------------------------------------------------
module two_class_priority_stack_core_tb;
    import tpstk_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 395;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    int fail_count;
    int pending;
    int n_results;
    int n_full;
    int n_empty_pop;
    int n_buried;
    int n_peak;

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_seq  = 0;
    int n_sent    = 0;
    int idle_plan[4]  = '{0, 80, 0, 30};
    int stall_plan[4] = '{0, 0, 80, 30};

    two_class_priority_stack_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tpstk_stack_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .pending     (pending),
        .n_results   (n_results),
        .n_full      (n_full),
        .n_empty_pop (n_empty_pop),
        .n_buried    (n_buried),
        .n_peak      (n_peak)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [15:0] id, input logic pri);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, id, op};
        s_tuser  <= pri;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        n_sent++;
    endtask

    task automatic random_burst(input int len);
        int          push_pct;
        int          r;
        logic [1:0]  op;
        logic [15:0] id;
        case ($urandom_range(2))
            0: push_pct = 75;
            1: push_pct = 25;
            default: push_pct = 50;
        endcase
        repeat (len) begin
            r = $urandom_range(99);
            if (r < 3)
                op = OP_UNUSED;
            else if (r < 3 + push_pct)
                op = $urandom_range(1) ? OP_PRIORITY_PUSH : OP_PUSH;
            else
                op = OP_POP;
            case ($urandom_range(15))
                0: id = '0;
                1: id = '1;
                default: id = 16'($urandom_range(16'hFFFF));
            endcase
            send_item(op, id, 1'($urandom_range(1)));
        end
    endtask

    task automatic drain_all();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
    endtask

    initial begin : stimulus
        int target;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        send_item(OP_POP, 16'h0000, 1'b0);
        send_item(OP_UNUSED, 16'hFFFF, 1'b1);
        send_item(OP_PRIORITY_PUSH, 16'h0000, 1'b0);
        send_item(OP_PUSH, 16'hFFFF, 1'b1);
        send_item(OP_PRIORITY_PUSH, 16'hA5A5, 1'b0);
        send_item(OP_PRIORITY_PUSH, 16'h5A5A, 1'b1);
        send_item(OP_PUSH, 16'h1234, 1'b0);
        send_item(OP_PRIORITY_PUSH, 16'h8001, 1'b0);
        send_item(OP_UNUSED, 16'h0000, 1'b0);
        for (int i = 0; i < 10; i++)
            send_item(i[0] ? OP_PRIORITY_PUSH : OP_PUSH, 16'($urandom_range(16'hFFFF)),
                      1'($urandom_range(1)));
        send_item(OP_PUSH, 16'hFFFF, 1'b1);
        send_item(OP_PRIORITY_PUSH, 16'h0000, 1'b0);
        send_item(OP_POP, 16'hFFFF, 1'b1);
        send_item(OP_POP, 16'h0000, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_plan[ph];
            stall_pct = stall_plan[ph];
            target    = n_sent + ITEMS_PER_PHASE;
            if (ph == 0 || ph == 3) begin
                hold_seq++;
                random_burst(40);
            end
            while (n_sent < target)
                random_burst($urandom_range(8, 40));
            drain_all();
        end

        repeat (10) @(posedge aclk);
        $display("Covered %0d items over four idling phases; %0d refused pushes when full,",
                 n_sent, n_full);
        $display("%0d pops when empty, %0d ordinary entries placed under a priority run, peak %0d.",
                 n_empty_pop, n_buried, n_peak);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
